>>> src/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types and constants for the grayscale darken and statistics block.
// ----------------------------------------------------------------------------
package gds_pkg;

    // Image geometry and queue sizing defaults
    localparam int IMAGE_SIDE_DEFAULT = 8;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Config port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_DARKEN_PERCENT = 1'b0;

    // Scaling: pix * (100 - pct) / 100, divide done as multiply by 2^19/100.
    // Exact for every product up to 255 * 100.
    localparam logic [7:0]  PCT_FULL    = 8'd100;
    localparam logic [12:0] SCALE_RECIP = 13'd5243;
    localparam int          SCALE_SHIFT = 19;

    localparam int PROD_W = 15;
    localparam int POS_W  = 6;
    localparam int PIX_W  = 8;

    // Item handed from the front end to the back end
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  pos;
        logic              first;
        logic              last;
    } gds_item_t;

    // Result produced by the back end
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             stats_valid;
        logic [PIX_W-1:0] min_value;
        logic [POS_W-1:0] min_position;
        logic [PIX_W-1:0] max_value;
        logic [POS_W-1:0] max_position;
        logic [PIX_W-1:0] mean_value;
    } gds_result_t;

endpackage

>>> src/gds_front.sv
// ----------------------------------------------------------------------------
// gds_front
// Accepts pixels, tracks raster position and forms the unscaled product.
// ----------------------------------------------------------------------------
module gds_front #(
    parameter int IMAGE_SIDE = gds_pkg::IMAGE_SIDE_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           darken_percent,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  logic [7:0]           pixel_data,
    output logic                 item_valid,
    input  logic                 item_ready,
    output gds_pkg::gds_item_t   item
);

    localparam int PIXEL_COUNT = IMAGE_SIDE * IMAGE_SIDE;
    localparam int CNT_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W+5:0]   cnt_ext;
    logic [6:0]         factor;
    logic               accept;
    logic               is_last;

    assign pixel_ready = item_ready;
    assign item_valid  = pixel_valid;
    assign accept      = pixel_valid && item_ready;
    assign is_last     = (cnt_reg == CNT_W'(PIXEL_COUNT - 1));
    assign cnt_ext     = {6'b0, cnt_reg};

    // Percent of 100 or more zeroes every pixel
    assign factor = (darken_percent >= gds_pkg::PCT_FULL) ? 7'd0
                  : 7'(gds_pkg::PCT_FULL - darken_percent);

    always_comb
    begin
        item.prod  = {7'b0, pixel_data} * {8'b0, factor};
        item.pos   = cnt_ext[5:0];
        item.first = (cnt_reg == '0);
        item.last  = is_last;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = is_last ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> src/gds_fifo.sv
// ----------------------------------------------------------------------------
// gds_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gds_fifo #(
    parameter int DEPTH = gds_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  gds_pkg::gds_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output gds_pkg::gds_item_t   pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gds_pkg::gds_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/gds_back.sv
// ----------------------------------------------------------------------------
// gds_back
// Scales pixels, keeps running min/max/sum and computes the image mean.
// ----------------------------------------------------------------------------
module gds_back #(
    parameter int IMAGE_SIDE = gds_pkg::IMAGE_SIDE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  gds_pkg::gds_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output gds_pkg::gds_result_t  result
);

    localparam int PIXEL_COUNT = IMAGE_SIDE * IMAGE_SIDE;
    localparam int CNT_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int SUM_W       = 8 + CNT_W;
    localparam int MP_W        = 2 * SUM_W + 1;
    localparam int SP_W        = gds_pkg::PROD_W + 13;
    // floor(2^SUM_W / N): quotient estimate is exact or one low
    localparam logic [SUM_W:0] MEAN_RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / PIXEL_COUNT);

    // Stage 1: scaled pixel
    logic        s1_v_reg;
    logic [7:0]  s1_pix_reg;
    logic [5:0]  s1_pos_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;

    // Running statistics
    logic [7:0]       run_min_reg;
    logic [7:0]       run_min_next;
    logic [5:0]       run_min_idx_reg;
    logic [5:0]       run_min_idx_next;
    logic [7:0]       run_max_reg;
    logic [7:0]       run_max_next;
    logic [5:0]       run_max_idx_reg;
    logic [5:0]       run_max_idx_next;
    logic [SUM_W-1:0] run_sum_reg;
    logic [SUM_W-1:0] run_sum_next;

    // Stage 2: statistics snapshot
    logic             s2_v_reg;
    logic [7:0]       s2_pix_reg;
    logic             s2_last_reg;
    logic [7:0]       s2_min_reg;
    logic [5:0]       s2_min_idx_reg;
    logic [7:0]       s2_max_reg;
    logic [5:0]       s2_max_idx_reg;
    logic [SUM_W-1:0] s2_sum_reg;

    // Stage 3: mean estimate
    logic             s3_v_reg;
    logic [7:0]       s3_pix_reg;
    logic             s3_last_reg;
    logic [7:0]       s3_min_reg;
    logic [5:0]       s3_min_idx_reg;
    logic [7:0]       s3_max_reg;
    logic [5:0]       s3_max_idx_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    logic [7:0]       s3_q0_reg;

    // Output register
    logic                  out_v_reg;
    gds_pkg::gds_result_t  out_reg;
    gds_pkg::gds_result_t  out_next;

    logic rdy_out;
    logic rdy3;
    logic rdy2;
    logic rdy1;
    logic load1;
    logic load2;
    logic load3;
    logic load_out;

    logic [SP_W-1:0]        scale_prod;
    logic [MP_W-1:0]        mean_prod;
    logic [SUM_W+7:0]       q0_times_n;
    logic [SUM_W+7:0]       mean_rem;
    logic [7:0]             mean_fix;

    assign rdy_out = !out_v_reg || result_ready;
    assign rdy3    = !s3_v_reg || rdy_out;
    assign rdy2    = !s2_v_reg || rdy3;
    assign rdy1    = !s1_v_reg || rdy2;

    assign item_ready = rdy1;
    assign load1      = item_valid && rdy1;
    assign load2      = s1_v_reg && rdy2;
    assign load3      = s2_v_reg && rdy3;
    assign load_out   = s3_v_reg && rdy_out;

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    assign scale_prod = {13'b0, item.prod} * {gds_pkg::PROD_W'(0), gds_pkg::SCALE_RECIP};
    assign mean_prod  = {(SUM_W + 1)'(0), s2_sum_reg} * {SUM_W'(0), MEAN_RECIP};
    assign q0_times_n = {SUM_W'(0), s3_q0_reg} * (SUM_W + 8)'(PIXEL_COUNT);
    assign mean_rem   = {8'b0, s3_sum_reg} - q0_times_n;
    assign mean_fix   = (mean_rem >= (SUM_W + 8)'(PIXEL_COUNT)) ? s3_q0_reg + 8'd1 : s3_q0_reg;

    // Running statistics update; first pixel overwrites, ties keep the earlier one
    always_comb
    begin
        if (s1_first_reg)
        begin
            run_min_next     = s1_pix_reg;
            run_min_idx_next = '0;
            run_max_next     = s1_pix_reg;
            run_max_idx_next = '0;
            run_sum_next     = SUM_W'(s1_pix_reg);
        end
        else
        begin
            run_min_next     = run_min_reg;
            run_min_idx_next = run_min_idx_reg;
            run_max_next     = run_max_reg;
            run_max_idx_next = run_max_idx_reg;
            if (s1_pix_reg < run_min_reg)
            begin
                run_min_next     = s1_pix_reg;
                run_min_idx_next = s1_pos_reg;
            end
            if (s1_pix_reg > run_max_reg)
            begin
                run_max_next     = s1_pix_reg;
                run_max_idx_next = s1_pos_reg;
            end
            run_sum_next = run_sum_reg + SUM_W'(s1_pix_reg);
        end
    end

    always_comb
    begin
        out_next.pixel_out    = s3_pix_reg;
        out_next.stats_valid  = s3_last_reg;
        out_next.min_value    = '0;
        out_next.min_position = '0;
        out_next.max_value    = '0;
        out_next.max_position = '0;
        out_next.mean_value   = '0;
        if (s3_last_reg)
        begin
            out_next.min_value    = s3_min_reg;
            out_next.min_position = s3_min_idx_reg;
            out_next.max_value    = s3_max_reg;
            out_next.max_position = s3_max_idx_reg;
            out_next.mean_value   = mean_fix;
        end
    end

    // Valid bits and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            s3_v_reg        <= 1'b0;
            out_v_reg       <= 1'b0;
            run_min_reg     <= '0;
            run_min_idx_reg <= '0;
            run_max_reg     <= '0;
            run_max_idx_reg <= '0;
            run_sum_reg     <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_v_reg <= item_valid;
            end
            if (rdy2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (rdy_out)
            begin
                out_v_reg <= s3_v_reg;
            end
            if (load2)
            begin
                run_min_reg     <= run_min_next;
                run_min_idx_reg <= run_min_idx_next;
                run_max_reg     <= run_max_next;
                run_max_idx_reg <= run_max_idx_next;
                run_sum_reg     <= run_sum_next;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_pix_reg   <= scale_prod[gds_pkg::SCALE_SHIFT +: 8];
            s1_pos_reg   <= item.pos;
            s1_first_reg <= item.first;
            s1_last_reg  <= item.last;
        end
        if (load2)
        begin
            s2_pix_reg     <= s1_pix_reg;
            s2_last_reg    <= s1_last_reg;
            s2_min_reg     <= run_min_next;
            s2_min_idx_reg <= run_min_idx_next;
            s2_max_reg     <= run_max_next;
            s2_max_idx_reg <= run_max_idx_next;
            s2_sum_reg     <= run_sum_next;
        end
        if (load3)
        begin
            s3_pix_reg     <= s2_pix_reg;
            s3_last_reg    <= s2_last_reg;
            s3_min_reg     <= s2_min_reg;
            s3_min_idx_reg <= s2_min_idx_reg;
            s3_max_reg     <= s2_max_reg;
            s3_max_idx_reg <= s2_max_idx_reg;
            s3_sum_reg     <= s2_sum_reg;
            s3_q0_reg      <= mean_prod[SUM_W +: 8];
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/gray_darken_and_statistics.sv
// ----------------------------------------------------------------------------
// gray_darken_and_statistics
// Grayscale pixel darkening with per-image min, max and mean.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle from the input stream while the output is not
// stalled, scales it by (100 - darken_percent) / 100 and returns one result
// per pixel; the last pixel of each IMAGE_SIDE x IMAGE_SIDE image also
// carries the darkest and brightest values with their first positions and
// the truncated mean (tuser = 1). The pixel lands in the input queue at the
// accepting edge, then passes the scale, statistics, mean estimate and mean
// correction/output stages. The running min/max/sum update sets the per-item
// pace. Positions wrap at 64. darken_percent sits at byte address 0.
module gray_darken_and_statistics #(
    parameter int IMAGE_SIDE = gds_pkg::IMAGE_SIDE_DEFAULT,
    parameter int FIFO_DEPTH = gds_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gds_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [gds_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [gds_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] pixel_out, [15:8] min_value, [21:16] min_position,
    // [29:22] max_value, [35:30] max_position, [43:36] mean_value, [47:44] zero
    output logic [47:0]                     m_tdata,
    output logic                            m_tuser    // [0] stats_valid
);

    logic [7:0]            darken_percent_reg;
    logic [7:0]            darken_percent_next;
    logic                  reg_sel;

    logic                  front_valid;
    logic                  front_ready;
    gds_pkg::gds_item_t    front_item;
    logic                  queue_valid;
    logic                  queue_ready;
    gds_pkg::gds_item_t    queue_item;
    gds_pkg::gds_result_t  res;

    // Register decode by word index
    assign reg_sel = (paddr[gds_pkg::CFG_ADDR_W-1:2] == gds_pkg::REG_DARKEN_PERCENT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'b0, darken_percent_reg} : '0;

    always_comb
    begin
        darken_percent_next = darken_percent_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            darken_percent_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            darken_percent_reg <= '0;
        end
        else
        begin
            darken_percent_reg <= darken_percent_next;
        end
    end

    gds_front #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .darken_percent (darken_percent_reg),
        .pixel_valid    (s_tvalid),
        .pixel_ready    (s_tready),
        .pixel_data     (s_tdata),
        .item_valid     (front_valid),
        .item_ready     (front_ready),
        .item           (front_item)
    );

    gds_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    gds_back #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_valid),
        .item_ready   (queue_ready),
        .item         (queue_item),
        .result_valid (m_tvalid),
        .result_ready (m_tready),
        .result       (res)
    );

    assign m_tdata = {4'b0, res.mean_value, res.max_position, res.max_value,
                      res.min_position, res.min_value, res.pixel_out};
    assign m_tuser = res.stats_valid;

endmodule
